FILE: rtl/ffc_pkg.sv
// types, constants and register codes shared by the compressor modules
package ffc_pkg;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 4'd3;

	localparam logic [14:0] THRESHOLD_RST = 15'd16384;
	localparam logic [15:0] RATIO_RST = 16'd1024;
	localparam logic [15:0] ATTACK_RST = 16'd64880;
	localparam logic [15:0] RELEASE_RST = 16'd65500;

	localparam logic [15:0] UNITY_GAIN = 16'd32768;
	localparam logic [15:0] RATIO_ONE = 16'd256;
	localparam logic [14:0] LEVEL_MAX = 15'd32767;

	// one quotient bit per step, gain is at most unity so 16 bits suffice
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_MUL_ENV  = 9'b000000010,
		S_UPD_ENV  = 9'b000000100,
		S_MUL_TR   = 9'b000001000,
		S_MUL_ER   = 9'b000010000,
		S_DIV_INIT = 9'b000100000,
		S_DIV      = 9'b001000000,
		S_MUL_OUT  = 9'b010000000,
		S_RESULT   = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		MUL_ENV = 2'd0,
		MUL_TR  = 2'd1,
		MUL_ER  = 2'd2,
		MUL_OUT = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     load_smp;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     upd_env;
		logic     load_s;
		logic     div_init;
		logic     div_step;
		logic     out_load;
	} ffc_cmd_t;

	typedef struct packed {
		logic bypass;
	} ffc_stat_t;

	typedef struct packed {
		logic [14:0] threshold_level;
		logic [15:0] ratio_q8;
		logic [15:0] attack_coef;
		logic [15:0] release_coef;
	} ffc_cfg_t;

endpackage

FILE: rtl/ffc_smp_if.sv
// input sample channel
interface ffc_smp_if import ffc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

FILE: rtl/ffc_res_if.sv
// result channel: compressed sample and applied gain
interface ffc_res_if import ffc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic [15:0]        applied_gain;

	modport source (output valid, output sample_out, output applied_gain, input ready);
	modport sink (input valid, input sample_out, input applied_gain, output ready);
endinterface

FILE: rtl/ffc_cfg_if.sv
// configuration write channel
interface ffc_cfg_if import ffc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ffc_cfg_regs.sv
// configuration register file
module ffc_cfg_regs import ffc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ffc_cfg_if.sink   cfg,
	output ffc_cfg_t  regs
);

	ffc_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.threshold_level <= THRESHOLD_RST;
			regs_q.ratio_q8 <= RATIO_RST;
			regs_q.attack_coef <= ATTACK_RST;
			regs_q.release_coef <= RELEASE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_THRESHOLD: regs_q.threshold_level <= cfg.data[14:0];
				REG_RATIO:     regs_q.ratio_q8 <= cfg.data;
				REG_ATTACK:    regs_q.attack_coef <= cfg.data;
				REG_RELEASE:   regs_q.release_coef <= cfg.data;
				default:       ;
			endcase
		end
	end

endmodule

FILE: rtl/ffc_ctrl.sv
// sequencer for envelope update, gain division and output product
module ffc_ctrl import ffc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ffc_stat_t stat,
	output ffc_cmd_t  cmd
);

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul_sel = MUL_ENV;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_smp = 1'b1;
					state_d = S_MUL_ENV;
				end
			end
			S_MUL_ENV: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_ENV;
				state_d = S_UPD_ENV;
			end
			S_UPD_ENV: begin
				cmd.upd_env = 1'b1;
				state_d = S_MUL_TR;
			end
			S_MUL_TR: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_TR;
				state_d = S_MUL_ER;
			end
			S_MUL_ER: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_ER;
				cmd.load_s = 1'b1;
				state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				// envelope at or below threshold: unity gain, no division
				state_d = stat.bypass ? S_MUL_OUT : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_MUL_OUT;
				end
			end
			S_MUL_OUT: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_OUT;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end else begin
				div_cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_MUL_ENV)
		else $error("accepted beat did not start the envelope multiply");

	a_div_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DIV |-> div_cnt_q == '0)
		else $error("division counter running outside the divide state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(out_valid_q) && !$past(cmd.out_load))
		else $error("pending result overwritten");

endmodule

FILE: rtl/ffc_dpath.sv
// sample, envelope, shared multiplier, restoring divider and result register
module ffc_dpath import ffc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ffc_cfg_t           regs,
	input  ffc_cmd_t           cmd,
	output ffc_stat_t          stat,
	input  logic signed [15:0] sample_in,
	output logic signed [15:0] sample_out,
	output logic [15:0]        applied_gain
);

	logic signed [15:0] smp_q;
	logic [14:0]        env_q;
	logic signed [35:0] prod_q;
	logic [31:0]        s_q;
	logic [31:0]        rem_q;
	logic [30:0]        den_q;
	logic [15:0]        gain_q;
	logic signed [15:0] res_smp_q;
	logic [15:0]        res_gain_q;

	logic               neg;
	logic [15:0]        mag;
	logic [14:0]        level;
	logic [15:0]        coef;
	logic signed [15:0] env_diff;
	logic [15:0]        ratio_eff;
	logic [14:0]        over_thr;
	logic signed [17:0] mul_a, mul_b;
	logic signed [32:0] env_acc;
	logic               rem_ge;
	logic [31:0]        rem_sub;
	logic [15:0]        res_mag;

	assign neg = smp_q[15];
	// -32768 gives magnitude 32768, level saturates at full scale
	assign mag = neg ? 16'(~smp_q + 16'sd1) : smp_q;
	assign level = mag[15] ? LEVEL_MAX : mag[14:0];
	assign coef = (level > env_q) ? regs.attack_coef : regs.release_coef;
	assign env_diff = $signed({1'b0, env_q}) - $signed({1'b0, level});
	assign ratio_eff = (regs.ratio_q8 < RATIO_ONE) ? RATIO_ONE : regs.ratio_q8;
	assign over_thr = env_q - regs.threshold_level;
	assign stat.bypass = (env_q <= regs.threshold_level);

	always_comb begin
		case (cmd.mul_sel)
			MUL_ENV: begin
				mul_a = $signed({2'b00, coef});
				mul_b = 18'(env_diff);
			end
			MUL_TR: begin
				mul_a = $signed({3'b000, regs.threshold_level});
				mul_b = $signed({2'b00, ratio_eff});
			end
			MUL_ER: begin
				mul_a = $signed({3'b000, env_q});
				mul_b = $signed({2'b00, ratio_eff});
			end
			MUL_OUT: begin
				mul_a = $signed({2'b00, mag});
				mul_b = $signed({2'b00, gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// c*env + (1-c)*L rewritten as L + c*(env - L)
	assign env_acc = $signed({2'b00, level, 16'd0}) + 33'(prod_q);

	assign rem_ge = rem_q >= {1'b0, den_q};
	assign rem_sub = rem_ge ? (rem_q - {1'b0, den_q}) : rem_q;

	assign res_mag = prod_q[30:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (cmd.upd_env) begin
			env_q <= env_acc[30:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_smp) begin
			smp_q <= sample_in;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.load_s) begin
			// threshold*ratio + (env - threshold)*256
			s_q <= 32'(prod_q[30:0]) + 32'({over_thr, 8'd0});
		end
		if (cmd.div_init) begin
			rem_q <= s_q;
			den_q <= prod_q[30:0];
			gain_q <= stat.bypass ? UNITY_GAIN : '0;
		end else if (cmd.div_step) begin
			rem_q <= {rem_sub[30:0], 1'b0};
			gain_q <= {gain_q[14:0], rem_ge};
		end
		if (cmd.out_load) begin
			res_smp_q <= neg ? $signed(16'(~res_mag + 16'd1)) : $signed(res_mag);
			res_gain_q <= gain_q;
		end
	end

	assign sample_out = res_smp_q;
	assign applied_gain = res_gain_q;

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en && cmd.mul_sel == MUL_OUT |-> gain_q <= UNITY_GAIN)
		else $error("gain above unity");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> {1'b0, rem_q} < {1'b0, den_q, 1'b0})
		else $error("division remainder out of range");

endmodule

FILE: rtl/feed_forward_compressor_core.sv
// Feed-forward peak compressor: one signed Q1.15 sample in, one compressed
// sample and its Q1.15 gain out. When the envelope is above the threshold,
// the gain is formed by the one-bit-per-cycle restoring divider; at or below
// it, the division is skipped and the gain is unity. A new sample is taken
// only once the previous one has reached the output register. The peak
// envelope resets to zero and the four registers (threshold, ratio, attack
// and release coefficients) reset to their defaults; they are written through
// the configuration channel, which is always ready and should be used only
// while no sample is in flight.
module feed_forward_compressor_core import ffc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ffc_cfg_if.sink   cfg,
	ffc_smp_if.sink   samples,
	ffc_res_if.source results
);

	ffc_cfg_t  regs;
	ffc_cmd_t  cmd;
	ffc_stat_t stat;

	ffc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ffc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.regs         (regs),
		.cmd          (cmd),
		.stat         (stat),
		.sample_in    (samples.sample_in),
		.sample_out   (results.sample_out),
		.applied_gain (results.applied_gain)
	);

endmodule

FILE: sim/feed_forward_compressor_core_tb.sv
// testbench for the feed-forward compressor core: random audio bursts checked against a predictor
`timescale 1ns / 100ps

module feed_forward_compressor_core_tb import ffc_pkg::*; ();

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic [15:0]        applied_gain;
	} comp_out_t;

	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER = 375;
	localparam int RANDOM_SETTINGS = 8;
	localparam int ITEMS_PER_SETTING = 140;

	logic clk;
	logic arst_n;

	ffc_cfg_if cfg_bus ();
	ffc_smp_if smp_bus ();
	ffc_res_if res_bus ();

	feed_forward_compressor_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.samples(smp_bus),
		.results(res_bus)
	);

	// register mirror and envelope of the predictor
	logic [14:0] thr_cfg;
	logic [15:0] ratio_cfg;
	logic [15:0] atk_cfg;
	logic [15:0] rel_cfg;
	logic [14:0] env_level;

	logic signed [15:0] sample_q [$];
	comp_out_t          compressed_q [$];

	logic src_idle;
	logic sink_idle;
	logic hold_off;
	int   src_wait;
	int   sink_wait;
	int   sink_draw;
	int   samples_taken;
	int   results_seen;
	int   reduced_cnt;
	int   errors;
	int   settings_run;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic comp_out_t compress_sample(input logic signed [15:0] smp);
		logic [16:0]     mag;
		logic [14:0]     lvl;
		logic [15:0]     coef;
		longint unsigned acc;
		longint unsigned num;
		longint unsigned den;
		longint unsigned r;
		logic [15:0]     gain;
		logic [31:0]     prod;
		comp_out_t       res;
		mag = smp[15] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
		lvl = (mag > 17'd32767) ? LEVEL_MAX : mag[14:0];
		coef = (lvl > env_level) ? atk_cfg : rel_cfg;
		acc = 64'(coef) * 64'(env_level) + (64'd65536 - 64'(coef)) * 64'(lvl);
		env_level = 15'(acc >> 16);
		if (env_level <= thr_cfg) begin
			gain = UNITY_GAIN;
		end else begin
			// ratios under one saturate to one
			r = (ratio_cfg < RATIO_ONE) ? 64'(RATIO_ONE) : 64'(ratio_cfg);
			num = (64'(thr_cfg) * r + (64'(env_level) - 64'(thr_cfg)) * 64'd256) * 64'd32768;
			den = r * 64'(env_level);
			gain = 16'(num / den);
		end
		prod = 32'((64'(mag) * 64'(gain)) >> 15);
		res.sample_out = smp[15] ? 16'(17'h10000 - prod[16:0]) : prod[15:0];
		res.applied_gain = gain;
		return res;
	endfunction

	task automatic check_result(input logic signed [15:0] got_smp, input logic [15:0] got_gain);
		comp_out_t want;
		results_seen++;
		if (compressed_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result %0d: sample_out %0d applied_gain %0d",
					results_seen, got_smp, got_gain);
		end else begin
			want = compressed_q.pop_front();
			if (want.applied_gain != UNITY_GAIN)
				reduced_cnt++;
			if (want.sample_out !== got_smp || want.applied_gain !== got_gain) begin
				errors++;
				if (errors <= 10)
					$display("mismatch at result %0d: sample_out exp %0d got %0d, gain exp %0d got %0d",
						results_seen, want.sample_out, got_smp, want.applied_gain, got_gain);
			end
		end
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_bus.valid <= 1'b0;
			smp_bus.sample_in <= '0;
			src_wait <= 0;
		end else begin
			if (smp_bus.valid && smp_bus.ready) begin
				compressed_q.push_back(compress_sample(smp_bus.sample_in));
				samples_taken++;
			end
			// a beat that is offered stays put until taken
			if (!(smp_bus.valid && !smp_bus.ready)) begin
				if (src_wait != 0) begin
					smp_bus.valid <= 1'b0;
					src_wait <= src_wait - 1;
				end else if (sample_q.size() != 0) begin
					smp_bus.valid <= 1'b1;
					smp_bus.sample_in <= sample_q.pop_front();
					src_wait <= src_idle ? int'($urandom_range(0, 7)) : 0;
				end else begin
					smp_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			sink_wait <= 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				check_result(res_bus.sample_out, res_bus.applied_gain);
				sink_draw = sink_idle ? int'($urandom_range(0, 7)) : 0;
				sink_wait <= sink_draw;
				res_bus.ready <= (sink_draw == 0) && !hold_off;
			end else if (sink_wait != 0) begin
				sink_wait <= sink_wait - 1;
				res_bus.ready <= (sink_wait == 1) && !hold_off;
			end else begin
				res_bus.ready <= !hold_off;
			end
		end
	end

	// long receiver stall while samples keep coming
	initial begin
		hold_off = 1'b0;
		do @(posedge clk); while (samples_taken < HOLD_AFTER);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_THRESHOLD: thr_cfg = val[14:0];
			REG_RATIO:     ratio_cfg = val;
			REG_ATTACK:    atk_cfg = val;
			REG_RELEASE:   rel_cfg = val;
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic cfg_all(input logic [15:0] thr, input logic [15:0] ratio,
			input logic [15:0] atk, input logic [15:0] rel);
		cfg_write(REG_THRESHOLD, thr);
		cfg_write(REG_RATIO, ratio);
		cfg_write(REG_ATTACK, atk);
		cfg_write(REG_RELEASE, rel);
	endtask

	// sampled away from the rising edge so driver and monitor updates have settled
	task automatic wait_drained();
		do @(negedge clk);
		while (sample_q.size() != 0 || smp_bus.valid || compressed_q.size() != 0);
	endtask

	// bursts of random level and length, with some full-range noise and extremes mixed in
	task automatic queue_random_audio(input int n);
		int amp;
		int len;
		int mag;
		while (n > 0) begin
			amp = $urandom_range(0, 1) ? $urandom_range(0, 32768) : $urandom_range(0, 2000);
			len = $urandom_range(3, 20);
			for (int i = 0; i < len && n > 0; i++) begin
				case ($urandom_range(0, 9))
					0: sample_q.push_back(16'($urandom));
					1: begin
						case ($urandom_range(0, 3))
							0: sample_q.push_back(16'h7FFF);
							1: sample_q.push_back(16'h8000);
							2: sample_q.push_back(16'hFFFF);
							default: sample_q.push_back(16'h0000);
						endcase
					end
					default: begin
						mag = $urandom_range(0, amp);
						sample_q.push_back($urandom_range(0, 1) ? 16'(-mag) : 16'(mag));
					end
				endcase
				n--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		smp_bus.valid = 1'b0;
		smp_bus.sample_in = '0;
		res_bus.ready = 1'b0;
		src_idle = 1'b0;
		sink_idle = 1'b0;
		samples_taken = 0;
		results_seen = 0;
		reduced_cnt = 0;
		errors = 0;
		settings_run = 1;
		thr_cfg = THRESHOLD_RST;
		ratio_cfg = RATIO_RST;
		atk_cfg = ATTACK_RST;
		rel_cfg = RELEASE_RST;
		env_level = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: zero, extremes, most negative sample, bit patterns
		sample_q = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
			16'h4000};
		wait_drained();

		// zero coefficients: envelope follows the level, at and just above the knee
		cfg_write(REG_ATTACK, 16'h0000);
		cfg_write(REG_RELEASE, 16'h0000);
		sample_q = '{16'h7FFF, 16'h8000, 16'h4000, 16'h4001, 16'hBFFF, 16'h0064, 16'h0000,
			16'h7D00};
		wait_drained();

		// ratio under one acts as one
		cfg_write(REG_RATIO, 16'h0000);
		sample_q = '{16'h7FFF, 16'hB1E0};
		wait_drained();
		cfg_write(REG_RATIO, 16'h00FF);
		sample_q = '{16'h7530};
		wait_drained();
		cfg_write(REG_RATIO, 16'hFFFF);
		sample_q = '{16'h8000};
		wait_drained();

		for (int p = 0; p < RANDOM_SETTINGS; p++) begin
			case (p)
				0: cfg_all(16'h8000, 16'hFFFF, 16'h0000, 16'h0000);
				1: cfg_all(16'h7FFF, 16'h0100, 16'hFFFF, 16'hFFFF);
				2: cfg_all(16'h2000, 16'h0000, 16'd30000, 16'd60000);
				3: cfg_all(16'h1000, 16'h00FF, 16'd1000, 16'd65000);
				4: cfg_all(16'd2000, 16'd2048, 16'd50000, 16'd64000);
				5: cfg_all(16'd20000, 16'd768, 16'h0000, 16'hFFFF);
				6: cfg_all(16'hAEE0, 16'd40000, 16'hFFFF, 16'h0000);
				default: cfg_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			// one setting in four runs with no idling at all
			src_idle = (p % 4 == 0) || (p % 4 == 2);
			sink_idle = (p % 4 == 0) || (p % 4 == 1);
			queue_random_audio(ITEMS_PER_SETTING);
			wait_drained();
			settings_run++;
		end

		repeat (40) @(posedge clk);
		$display("%0d samples over %0d register settings, %0d of them with gain reduction",
			samples_taken, settings_run, reduced_cnt);
		$display("%0d results checked, %0d mismatches", results_seen, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout after %0d samples and %0d results", samples_taken, results_seen);
		$display("== FAIL ==");
		$finish;
	end

endmodule
